/* hw/rtl/lfsa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared types and constants for the lowest free slot allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

  localparam int unsigned SLOTS_DEF = 64;
  localparam int unsigned SLOT_W    = 7;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned GROUP     = 16;
  localparam int unsigned GLOW_W    = 4;

  localparam logic [SLOT_W-1:0] CFG_RESET = 7'd64;

  typedef struct packed {
    logic load;
    logic rel;
    logic grp;
    logic pick;
    logic rd;
    logic wr;
  } cmd_t;

  typedef struct packed {
    logic found;
  } status_t;

endpackage

/* hw/rtl/lowest_free_slot_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lowest_free_slot_allocator
// Interval allocator: frees expired slots, grants the lowest free one.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_valid_i/in_stall_o  in_start_time_i, in_end_time_i
// out      out  out_valid_o/out_stall_i out_slot_o, out_full_res_o, out_uses_o
// cfg      in   cfg_valid_i/cfg_ready_o cfg_data_i (slots_enabled)
//
// A request runs these steps from accept to the next accept, full or not:
// lane compare, group encode, group select, count memory read, write.
// A stalled result holds the write step until the output register drains.
// Reset is immediate; no clearing pass is needed.
// ----------------------------------------------------------------------------
module lowest_free_slot_allocator
  import lfsa_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SLOT_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TIME_W-1:0] in_start_time_i,
  input  logic [TIME_W-1:0] in_end_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SLOT_W-1:0] out_slot_o,
  output logic              out_full_res_o,
  output logic [CNT_W-1:0]  out_uses_o
);

  cmd_t    cmd;
  status_t sts;

  assign cfg_ready_o = 1'b1;

  lfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lfsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .start_time_i (in_start_time_i),
    .end_time_i   (in_end_time_i),
    .slot_o       (out_slot_o),
    .full_res_o   (out_full_res_o),
    .uses_o       (out_uses_o)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted beat did not start work");

  a_full_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_full_res_o |-> out_slot_o == '0 && out_uses_o == '0)
    else $error("full beat carries a slot or count");

  a_grant_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_full_res_o |-> out_slot_o != '0 && out_uses_o != '0)
    else $error("granted beat has no slot or count");
`endif

endmodule

/* hw/rtl/lfsa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_ctrl
// Sequencer for one request: release, group scan, pick, count read, write.
// ----------------------------------------------------------------------------
module lfsa_ctrl
  import lfsa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REL  = 3'd1;
  localparam logic [2:0] ST_GRP  = 3'd2;
  localparam logic [2:0] ST_PICK = 3'd3;
  localparam logic [2:0] ST_RD   = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_REL;
        end
      end
      ST_REL: begin
        cmd_o.rel = 1'b1;
        state_d   = ST_GRP;
      end
      ST_GRP: begin
        cmd_o.grp = 1'b1;
        state_d   = ST_PICK;
      end
      ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = ST_RD;
      end
      ST_RD: begin
        cmd_o.rd = sts_i.found;
        state_d  = ST_WR;
      end
      ST_WR: begin
        if (!(out_valid_q && out_stall_i)) begin
          cmd_o.wr    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* hw/rtl/lfsa_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfsa_dp
// Slot state, release compare lanes, grouped priority search, use counters.
// ----------------------------------------------------------------------------
module lfsa_dp
  import lfsa_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           sts_o,
  input  logic              cfg_we_i,
  input  logic [SLOT_W-1:0] cfg_data_i,
  input  logic [TIME_W-1:0] start_time_i,
  input  logic [TIME_W-1:0] end_time_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic              full_res_o,
  output logic [CNT_W-1:0]  uses_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned NG    = (SLOTS + GROUP - 1) / GROUP;
  localparam int unsigned CW    = (IDX_W + 1 > SLOT_W) ? IDX_W + 1 : SLOT_W;

  logic [SLOT_W-1:0] cfg_q;
  logic [TIME_W-1:0] start_q, end_q;
  logic [SLOTS-1:0]  busy_q;
  logic [TIME_W-1:0] rel_q [SLOTS];
  logic [NG-1:0]     grp_any_q, grp_any_d;
  logic [GLOW_W-1:0] grp_low_q [NG];
  logic [GLOW_W-1:0] grp_low_d [NG];
  logic [IDX_W-1:0]  pick_q, pick_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  cnt_mem [SLOTS];
  logic [SLOTS-1:0]  cnt_vld_q;
  logic [CNT_W-1:0]  rd_q;
  logic              rd_vld_q;
  logic [CNT_W-1:0]  cur_cnt, nxt_cnt;
  logic [SLOTS-1:0]  free;
  logic [SLOT_W-1:0] slot_q;
  logic              full_q;
  logic [CNT_W-1:0]  uses_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q <= start_time_i;
      end_q   <= end_time_i;
    end
  end

  // release lanes, then mark the chosen slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (cmd_i.rel) begin
      for (int i = 0; i < SLOTS; i++) begin
        busy_q[i] <= busy_q[i] && !(rel_q[i] <= start_q);
      end
    end else if (cmd_i.rd) begin
      busy_q[pick_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rel_q[pick_q] <= end_q;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free[i] = !busy_q[i] && (CW'(i) < CW'(cfg_q));
    end
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_any_d[g] = 1'b0;
      grp_low_d[g] = '0;
      for (int j = GROUP - 1; j >= 0; j--) begin
        if (g * GROUP + j < SLOTS) begin
          if (free[g * GROUP + j]) begin
            grp_any_d[g] = 1'b1;
            grp_low_d[g] = GLOW_W'(j);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grp) begin
      grp_any_q <= grp_any_d;
      grp_low_q <= grp_low_d;
    end
  end

  always_comb begin
    found_d = 1'b0;
    pick_d  = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found_d = 1'b1;
        pick_d  = IDX_W'(g * GROUP + int'(grp_low_q[g]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.pick) begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pick) begin
      pick_q <= pick_d;
    end
  end

  // use counters: memory plus a valid bit per entry for the cleared state
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q <= cnt_mem[pick_q];
    end
    if (cmd_i.wr && found_q) begin
      cnt_mem[pick_q] <= nxt_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.rd) begin
        rd_vld_q <= cnt_vld_q[pick_q];
      end
      if (cmd_i.wr && found_q) begin
        cnt_vld_q[pick_q] <= 1'b1;
      end
    end
  end

  assign cur_cnt = rd_vld_q ? rd_q : '0;
  assign nxt_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      slot_q <= found_q ? SLOT_W'({1'b0, pick_q} + (IDX_W + 1)'(1)) : '0;
      full_q <= !found_q;
      uses_q <= found_q ? nxt_cnt : '0;
    end
  end

  assign sts_o.found = found_q;
  assign slot_o      = slot_q;
  assign full_res_o  = full_q;
  assign uses_o      = uses_q;

endmodule
